FILE: rtl/core/ism_pkg.sv
package ism_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLICE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_SLICE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CENTER_WEIGHT = 2'd2;

    // Fixed field widths
    localparam int PIX_W = 16;
    localparam int DIM_W = 6;
    localparam int WGT_W = 8;
    localparam int POS_W = 5;
    localparam int MAG_W = 24;
    localparam int DVS_W = WGT_W + 1;

    // Dimension limits
    localparam logic [DIM_W-1:0] DIM_MIN    = 6'd3;
    localparam logic [DIM_W-1:0] HEIGHT_MAX = 6'd32;
    localparam logic [DVS_W-1:0] NEIGH_SUM  = 9'd8;

    // Divider request
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

FILE: rtl/core/ism_div.sv
module ism_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ism_pkg::div_req_t             req,
    output logic                          done,
    output logic signed [ism_pkg::PIX_W-1:0] quotient
);
    import ism_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // One restoring step per cycle
    always_comb begin
        trial = {rem_reg, quot_reg[MAG_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'(MAG_W);
            rem_next  = '0;
            quot_next = req.mag;
            dvs_next  = req.divisor;
            neg_next  = req.neg;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quot_next = {quot_reg[MAG_W-2:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    // Sign and saturate the quotient
    always_comb begin
        if (neg_reg) begin
            if (quot_reg > 24'd32768) quotient = -16'sd32768;
            else quotient = $signed(16'(~quot_reg[PIX_W-1:0] + 16'd1));
        end else begin
            if (quot_reg > 24'd32767) quotient = 16'sd32767;
            else quotient = $signed(quot_reg[PIX_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

FILE: rtl/core/inplace_weighted_3x3_smoother.sv
// An item that does not end a row is written to the row memory as it is taken.
// An item ending a row after the first emits the previous row: the window is primed, then
// each border pixel passes header, 4 memory reads, result and handshake, and interior
// pixels add multiply/add and the one-bit-per-step divider; the last column skips the reads.
// Final row flushed by a read and a result per pixel; one item in work at a time, stalls hold it.
// Reset (aresetn low, synchronous) restores registers 32/32/8 and slice position 0.
module inplace_weighted_3x3_smoother #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [ism_pkg::WGT_W-1:0]          cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ism_pkg::PIX_W-1:0]   s_pixel_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ism_pkg::PIX_W-1:0]   m_pixel_out,
    output logic [ism_pkg::POS_W-1:0]          m_out_row,
    output logic [ism_pkg::POS_W-1:0]          m_out_col,
    output logic                               m_last_of_run
);
    import ism_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int K_W   = COL_W + 1;
    localparam int ADR_W = COL_W + 2;
    localparam int DEPTH = 4 * MAX_WIDTH;
    localparam logic [DIM_W-1:0] MAX_W6 = DIM_W'(MAX_WIDTH);

    localparam logic [3:0] S_IN   = 4'd0;
    localparam logic [3:0] S_HEAD = 4'd1;
    localparam logic [3:0] S_RD0  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_RD3  = 4'd5;
    localparam logic [3:0] S_CALC = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_DST  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;
    localparam logic [3:0] S_FR0  = 4'd11;
    localparam logic [3:0] S_FR1  = 4'd12;
    localparam logic [3:0] S_FEM  = 4'd13;

    // Configuration registers
    logic [DIM_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [WGT_W-1:0] cfg_wt_reg;
    // Per-slice settings
    logic [DIM_W-1:0] use_w_reg, use_h_reg;
    logic [WGT_W-1:0] use_wt_reg;

    logic [3:0]       state_reg;
    logic [COL_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [K_W-1:0]   k_reg;
    logic [1:0]       sa_reg, sm_reg, si_reg;

    // Window registers
    logic signed [PIX_W-1:0] a0_reg, a1_reg, a2_reg;
    logic signed [PIX_W-1:0] i0_reg, i1_reg, i2_reg;
    logic signed [PIX_W-1:0] m1_reg, m2_reg, left_reg;
    logic signed [24:0]      prod_reg;
    logic signed [18:0]      sum_reg;
    logic signed [25:0]      acc_reg;

    logic signed [PIX_W-1:0] out_pix_reg;
    logic [POS_W-1:0]        out_row_reg, out_col_reg;
    logic                    out_last_reg;

    // Row memory: three row slots addressed {slot, column}
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic [ADR_W-1:0] raddr, waddr;
    logic             we;
    logic [PIX_W-1:0] wdata;

    div_req_t                div_req;
    logic                    div_done;
    logic signed [PIX_W-1:0] div_q;

    logic             first_px, row_end, last_row, in_acc, out_acc;
    logic [DIM_W-1:0] cw_clamp, ch_clamp, eff_w;
    logic [K_W-1:0]   c_k;
    logic [COL_W-1:0] kc, cc;
    logic             c_last, border;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IN);
    assign m_valid   = (state_reg == S_EMIT) || (state_reg == S_FEM);
    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;

    // Clamp configured dimensions
    always_comb begin
        cw_clamp = (cfg_w_reg < DIM_MIN) ? DIM_MIN : (cfg_w_reg > MAX_W6) ? MAX_W6 : cfg_w_reg;
        ch_clamp = (cfg_h_reg < DIM_MIN) ? DIM_MIN :
                   (cfg_h_reg > HEIGHT_MAX) ? HEIGHT_MAX : cfg_h_reg;
    end

    assign first_px = (col_reg == '0) && (row_reg == '0);
    assign eff_w    = first_px ? cw_clamp : use_w_reg;
    assign row_end  = (DIM_W'(col_reg) + 6'd1) >= eff_w;
    assign last_row = (DIM_W'(row_reg) + 6'd1) >= use_h_reg;
    assign kc       = k_reg[COL_W-1:0];
    assign c_k      = k_reg - K_W'(1);
    assign cc       = c_k[COL_W-1:0];
    assign c_last   = (DIM_W'(k_reg) == use_w_reg);
    assign border   = (row_reg == 5'd1) || (c_k == '0) || c_last;

    // Memory port selection
    always_comb begin
        case (state_reg)
            S_RD0:   raddr = {sa_reg, kc};
            S_RD1:   raddr = {sm_reg, kc};
            S_RD2:   raddr = {si_reg, kc};
            default: raddr = {si_reg, kc};
        endcase
        we    = 1'b0;
        waddr = {si_reg, col_reg};
        wdata = s_pixel_in;
        if (in_acc) begin
            we = 1'b1;
        end else if ((state_reg == S_EMIT) && out_acc) begin
            we    = 1'b1;
            waddr = {sm_reg, cc};
            wdata = out_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // Divider request
    always_comb begin
        div_req.start   = (state_reg == S_DST);
        div_req.neg     = acc_reg[25];
        div_req.mag     = acc_reg[25] ? 24'(-acc_reg) : acc_reg[MAG_W-1:0];
        div_req.divisor = {1'b0, use_wt_reg} + NEIGH_SUM;
    end

    ism_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg  <= 6'd32;
            cfg_h_reg  <= 6'd32;
            cfg_wt_reg <= 8'd8;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SLICE_WIDTH:   cfg_w_reg  <= cfg_data[DIM_W-1:0];
                CFG_SLICE_HEIGHT:  cfg_h_reg  <= cfg_data[DIM_W-1:0];
                CFG_CENTER_WEIGHT: cfg_wt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IN;
            col_reg    <= '0;
            row_reg    <= '0;
            k_reg      <= '0;
            sa_reg     <= 2'd0;
            sm_reg     <= 2'd1;
            si_reg     <= 2'd2;
            use_w_reg  <= MAX_W6;
            use_h_reg  <= 6'd32;
            use_wt_reg <= 8'd8;
        end else begin
            case (state_reg)
                S_IN: begin
                    if (in_acc) begin
                        if (first_px) begin
                            use_w_reg  <= cw_clamp;
                            use_h_reg  <= ch_clamp;
                            use_wt_reg <= cfg_wt_reg;
                        end
                        if (!row_end) begin
                            col_reg <= col_reg + COL_W'(1);
                        end else begin
                            col_reg <= '0;
                            if (row_reg != '0) begin
                                k_reg     <= '0;
                                state_reg <= S_HEAD;
                            end else begin
                                sm_reg  <= si_reg;
                                si_reg  <= sm_reg;
                                row_reg <= row_reg + 5'd1;
                            end
                        end
                    end
                end
                S_HEAD: state_reg <= c_last ? S_CALC : S_RD0;
                S_RD0:  state_reg <= S_RD1;
                S_RD1:  state_reg <= S_RD2;
                S_RD2:  state_reg <= S_RD3;
                S_RD3:  state_reg <= S_CALC;
                S_CALC: begin
                    if (k_reg == '0) begin
                        k_reg     <= K_W'(1);
                        state_reg <= S_HEAD;
                    end else begin
                        state_reg <= border ? S_EMIT : S_MUL;
                    end
                end
                S_MUL: state_reg <= S_DST;
                S_DST: state_reg <= S_DIV;
                S_DIV: if (div_done) state_reg <= S_EMIT;
                S_EMIT: begin
                    if (m_ready) begin
                        k_reg <= k_reg + K_W'(1);
                        if (!c_last) begin
                            state_reg <= S_HEAD;
                        end else if (last_row) begin
                            k_reg     <= '0;
                            state_reg <= S_FR0;
                        end else begin
                            sa_reg    <= sm_reg;
                            sm_reg    <= si_reg;
                            si_reg    <= sa_reg;
                            row_reg   <= row_reg + 5'd1;
                            state_reg <= S_IN;
                        end
                    end
                end
                S_FR0: state_reg <= S_FR1;
                S_FR1: state_reg <= S_FEM;
                S_FEM: begin
                    if (m_ready) begin
                        k_reg <= k_reg + K_W'(1);
                        if (DIM_W'(k_reg) + 6'd1 == use_w_reg) begin
                            row_reg   <= '0;
                            state_reg <= S_IN;
                        end else begin
                            state_reg <= S_FR0;
                        end
                    end
                end
                default: state_reg <= S_IN;
            endcase
        end
    end

    // Datapath: window, arithmetic and result registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_RD1: a2_reg <= $signed(rdata_reg);
            S_RD2: m2_reg <= $signed(rdata_reg);
            S_RD3: i2_reg <= $signed(rdata_reg);
            S_CALC: begin
                if (k_reg == '0) begin
                    a1_reg <= a2_reg;
                    m1_reg <= m2_reg;
                    i1_reg <= i2_reg;
                end else begin
                    out_pix_reg  <= m1_reg;
                    out_row_reg  <= row_reg - 5'd1;
                    out_col_reg  <= POS_W'(cc);
                    out_last_reg <= c_last && !last_row;
                    prod_reg     <= 25'(m1_reg) * 25'($signed({1'b0, use_wt_reg}));
                    sum_reg      <= 19'(a0_reg) + 19'(a1_reg) + 19'(a2_reg) + 19'(left_reg)
                                  + 19'(m2_reg) + 19'(i0_reg) + 19'(i1_reg) + 19'(i2_reg);
                end
            end
            S_MUL: acc_reg <= 26'(prod_reg) + 26'(sum_reg);
            S_DIV: if (div_done) out_pix_reg <= div_q;
            S_EMIT: begin
                if (m_ready) begin
                    a0_reg   <= a1_reg;
                    a1_reg   <= a2_reg;
                    m1_reg   <= m2_reg;
                    i0_reg   <= i1_reg;
                    i1_reg   <= i2_reg;
                    left_reg <= out_pix_reg;
                end
            end
            S_FR1: begin
                out_pix_reg  <= $signed(rdata_reg);
                out_row_reg  <= row_reg;
                out_col_reg  <= POS_W'(kc);
                out_last_reg <= (DIM_W'(k_reg) + 6'd1 == use_w_reg);
            end
            default: ;
        endcase
    end

    assign m_pixel_out   = out_pix_reg;
    assign m_out_row     = out_row_reg;
    assign m_out_col     = out_col_reg;
    assign m_last_of_run = out_last_reg;

endmodule

FILE: rtl/core/ism_checker.sv
module ism_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [ism_pkg::PIX_W-1:0] m_pixel_out,
    input logic                             m_last_of_run
);
    // Input is never taken while a result is offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // More results of the same run follow before new input
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> !s_ready)
        else $error("input taken inside a result run");

    // No result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_out)))
        else $error("stalled result changed");

endmodule

bind inplace_weighted_3x3_smoother ism_checker u_ism_checker (.*);

FILE: bench/inplace_weighted_3x3_smoother_checker.sv
module inplace_weighted_3x3_smoother_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [ism_pkg::WGT_W-1:0]        cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic signed [ism_pkg::PIX_W-1:0] s_pixel_in,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic signed [ism_pkg::PIX_W-1:0] m_pixel_out,
    input  logic [ism_pkg::POS_W-1:0]        m_out_row,
    input  logic [ism_pkg::POS_W-1:0]        m_out_col,
    input  logic                             m_last_of_run,
    output int                               pending,
    output int                               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import ism_pkg::*;

    typedef struct {
        logic signed [PIX_W-1:0] pix;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic                    last;
    } smoothed_pixel_t;

    smoothed_pixel_t expected_pixels[$];

    // register shadows and per-slice latched settings
    logic [DIM_W-1:0] reg_width, reg_height;
    logic [WGT_W-1:0] reg_weight;
    int               cur_width, cur_height, cur_weight;
    int               above_row[32], middle_row[32], incoming_row[32];
    int               col_pos, row_pos;

    function automatic int clamp_dim(int v);
        if (v < 3) return 3;
        if (v > 32) return 32;
        return v;
    endfunction

    task automatic push_pixel(int val, int row, int col);
        smoothed_pixel_t e;
        e.pix  = val[PIX_W-1:0];
        e.row  = row[POS_W-1:0];
        e.col  = col[POS_W-1:0];
        e.last = 1'b0;
        expected_pixels.push_back(e);
    endtask

    // one accepted pixel: update row stores, emit finished rows
    task automatic smooth_pixel(int pix);
        int     filtered[32];
        longint acc, q;
        int     mid;
        int     n_before;
        n_before = expected_pixels.size();
        if (col_pos == 0 && row_pos == 0) begin
            cur_width  = clamp_dim(reg_width);
            cur_height = clamp_dim(reg_height);
            cur_weight = reg_weight;
        end
        incoming_row[col_pos] = pix;
        if (col_pos + 1 < cur_width) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos >= 1) begin
            mid = row_pos - 1;
            for (int x = 0; x < cur_width; x++) begin
                if (mid == 0 || x == 0 || x + 1 == cur_width) begin
                    filtered[x] = middle_row[x];
                end else begin
                    acc = longint'(middle_row[x]) * cur_weight;
                    acc += above_row[x-1] + above_row[x] + above_row[x+1];
                    acc += filtered[x-1] + middle_row[x+1];
                    acc += incoming_row[x-1] + incoming_row[x] + incoming_row[x+1];
                    q = acc / (cur_weight + 8);
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    filtered[x] = int'(q);
                end
                push_pixel(filtered[x], mid, x);
            end
            for (int x = 0; x < cur_width; x++) above_row[x] = filtered[x];
        end
        if (row_pos + 1 >= cur_height) begin
            for (int x = 0; x < cur_width; x++) push_pixel(incoming_row[x], row_pos, x);
            row_pos = 0;
        end else begin
            middle_row = incoming_row;
            row_pos++;
        end
        if (expected_pixels.size() > n_before)
            expected_pixels[expected_pixels.size()-1].last = 1'b1;
    endtask

    assign pending = expected_pixels.size();

    always @(posedge aclk) begin
        smoothed_pixel_t e;
        if (!aresetn) begin
            reg_width  <= 6'd32;
            reg_height <= 6'd32;
            reg_weight <= 8'd8;
            col_pos = 0;
            row_pos = 0;
        end else begin
            // compare result transaction with oldest expectation
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: pix=%0d row=%0d col=%0d",
                                 m_pixel_out, m_out_row, m_out_col);
                    mismatches++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (m_pixel_out !== e.pix || m_out_row !== e.row ||
                        m_out_col !== e.col || m_last_of_run !== e.last) begin
                        if (mismatches < 10)
                            $display("mismatch: exp pix=%0d row=%0d col=%0d last=%0b, got pix=%0d row=%0d col=%0d last=%0b",
                                     e.pix, e.row, e.col, e.last,
                                     m_pixel_out, m_out_row, m_out_col, m_last_of_run);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLICE_WIDTH:   reg_width  <= cfg_data[DIM_W-1:0];
                    CFG_SLICE_HEIGHT:  reg_height <= cfg_data[DIM_W-1:0];
                    CFG_CENTER_WEIGHT: reg_weight <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) smooth_pixel(int'(s_pixel_in));
        end
    end

    initial mismatches = 0;
endmodule

FILE: bench/inplace_weighted_3x3_smoother_test.sv
module inplace_weighted_3x3_smoother_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ism_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = CFG_SLICE_WIDTH;
    logic [WGT_W-1:0]          cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [PIX_W-1:0]   s_pixel_in = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [PIX_W-1:0]   m_pixel_out;
    logic [POS_W-1:0]          m_out_row, m_out_col;
    logic                      m_last_of_run;
    int                        pending, mismatches;
    int                        cycle_count = 0;
    int                        burst_left = 0;
    int                        items_sent = 0;

    localparam int CYCLE_LIMIT = 600000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    inplace_weighted_3x3_smoother dut (.*);

    inplace_weighted_3x3_smoother_checker checker_i (.*);

    // receiver stall pattern: the mode is redrawn at regular intervals
    always @(posedge aclk) begin
        int mode;
        if (cycle_count % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (cycle_count % 4 == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("inplace_weighted_3x3_smoother test failed");
            $finish;
        end
    end

    // valid stays high across back-to-back writes; the caller lowers it
    task automatic write_reg(logic [1:0] idx, logic [WGT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // wait until the block has drained, then write all three registers
    task automatic set_slice(logic [WGT_W-1:0] w, logic [WGT_W-1:0] h, logic [WGT_W-1:0] wt);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        write_reg(CFG_SLICE_WIDTH, w);
        write_reg(CFG_SLICE_HEIGHT, h);
        write_reg(CFG_CENTER_WEIGHT, wt);
        cfg_valid <= 1'b0;
    endtask

    // one pixel transaction, with bursty gaps before it
    task automatic send_pixel(logic signed [PIX_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_pixel_in <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic signed [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int clamp_dim(int v);
        if (v < 3) return 3;
        if (v > 32) return 32;
        return v;
    endfunction

    task automatic send_slice(int w, int h, bit drain_midway);
        int total;
        total = clamp_dim(w % 64) * clamp_dim(h % 64);
        for (int i = 0; i < total; i++) begin
            if (drain_midway && i == total / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            send_pixel(rand_pixel());
        end
    endtask

    initial begin
        int w, h;
        logic signed [PIX_W-1:0] corners[9];
        corners = '{16'sh7fff, 16'sh8000, 16'sh0000,
            16'shffff, 16'sh0001, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // smallest slice, zero center weight, extreme pixels
        set_slice(8'd3, 8'd3, 8'd0);
        foreach (corners[i]) send_pixel(corners[i]);
        // saturated weight, all maximum then out-of-range low dims
        set_slice(8'd0, 8'd1, 8'd255);
        for (int i = 0; i < 9; i++) send_pixel(16'sh7fff);
        // widest slice via oversize width, height minimum
        set_slice(8'd63, 8'd3, 8'd1);
        send_slice(63, 3, 1'b0);
        // oversize height clamps to 32 rows
        set_slice(8'd3, 8'd40, 8'd255);
        send_slice(3, 40, 1'b1);

        // random slices, mostly small
        while (items_sent < 380) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(0, 255);
                h = $urandom_range(0, 4);
            end else begin
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 8);
            end
            set_slice(w[7:0], h[7:0], 8'($urandom));
            send_slice(w, h, $urandom_range(0, 5) == 0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("inplace_weighted_3x3_smoother test passed");
        end else begin
            $display("inplace_weighted_3x3_smoother test failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/ism_pkg.sv
rtl/core/ism_div.sv
rtl/core/inplace_weighted_3x3_smoother.sv
rtl/core/ism_checker.sv
bench/inplace_weighted_3x3_smoother_checker.sv
bench/inplace_weighted_3x3_smoother_test.sv
